// ===== sv/tls_pkg.sv =====
// Shared types, constants and helper functions of the Tcl list splitter.
package tls_pkg;

  localparam int MAX_NESTING = 255;
  localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);
  localparam int HEX_SIG_MAX = 16;
  localparam int HEX_SIG_W   = $clog2(HEX_SIG_MAX + 2);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_FF     = 8'hff;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_JUNK_BRACE = 3'd1;
  localparam logic [2:0] ERR_JUNK_QUOTE = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED   = 3'd3;
  localparam logic [2:0] ERR_NESTING    = 3'd4;

  typedef enum logic [2:0] {
    MODE_BETWEEN,
    MODE_BARE,
    MODE_BRACED,
    MODE_QUOTED,
    MODE_AFTER_BRACE,
    MODE_AFTER_QUOTE,
    MODE_DISCARD
  } mode_t;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_BS,
    PH_X,
    PH_HEX,
    PH_OCT,
    PH_NL
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eend;
    logic       done;
    logic [2:0] err;
  } res_t;

  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } bundle_t;

  function automatic res_t mk_res(logic [7:0] data, logic valid, logic eend, logic done,
                                  logic [2:0] err);
    res_t r;
    r.data  = valid ? data : 8'h00;
    r.valid = valid;
    r.eend  = eend;
    r.done  = done;
    r.err   = err;
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= 8'h0d));
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  // Returns {hit, code} for the single-letter escapes.
  function automatic logic [8:0] named_escape(logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0b};
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

endpackage

// ===== sv/tls_front.sv =====
// Front end: accepts list bytes, tracks parse state and forms result bundles.
module tls_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              push,
  output tls_pkg::bundle_t  push_data
);

  tls_pkg::mode_t                  mode, mode_next;
  tls_pkg::phase_t                 phase, phase_next;
  logic [tls_pkg::DEPTH_W-1:0]     depth, depth_next;
  logic [7:0]                      esc_value, esc_value_next;
  logic [1:0]                      esc_digits, esc_digits_next;
  logic [tls_pkg::HEX_SIG_W-1:0]   hex_sig, hex_sig_next;
  logic                            hex_ovf, hex_ovf_next;
  logic [2:0]                      held, held_next;

  tls_pkg::phase_t                 e_phase;
  logic [7:0]                      e_value;
  logic [1:0]                      e_digits;
  logic [tls_pkg::HEX_SIG_W-1:0]   e_sig, sig_inc;
  logic                            e_ovf;
  logic                            pre_emit, run_plain;
  logic [7:0]                      pre_char;
  logic [8:0]                      named;
  logic [3:0]                      hv;
  logic [7:0]                      oct_val;

  logic                            fire, c_nul, c_ws;
  logic                            a_en, b_en;
  tls_pkg::res_t                   ra, rb;

  assign fire    = in_valid & in_ready;
  assign c_nul   = (in_byte == tls_pkg::CH_NUL);
  assign c_ws    = tls_pkg::is_ws(in_byte);
  assign named   = tls_pkg::named_escape(in_byte);
  assign hv      = tls_pkg::hex_val(in_byte);
  assign oct_val = {esc_value[4:0], in_byte[2:0]};

  // Escape collapse for bare and quoted elements.
  always_comb begin
    e_phase   = phase;
    e_value   = esc_value;
    e_digits  = esc_digits;
    e_sig     = hex_sig;
    e_ovf     = hex_ovf;
    sig_inc   = hex_sig;
    pre_emit  = 1'b0;
    pre_char  = in_byte;
    run_plain = 1'b0;
    unique case (phase)
      tls_pkg::PH_NONE: begin
        run_plain = 1'b1;
      end
      tls_pkg::PH_BS: begin
        e_phase = tls_pkg::PH_NONE;
        if (c_nul) begin
          pre_emit  = 1'b1;
          pre_char  = tls_pkg::CH_BSLASH;
          run_plain = 1'b1;
        end else if (named[8]) begin
          pre_emit = 1'b1;
          pre_char = named[7:0];
        end else if (in_byte == tls_pkg::CH_X) begin
          e_phase = tls_pkg::PH_X;
        end else if (in_byte == tls_pkg::CH_NL) begin
          e_phase = tls_pkg::PH_NL;
        end else if (tls_pkg::is_oct(in_byte)) begin
          e_value  = {5'd0, in_byte[2:0]};
          e_digits = 2'd1;
          e_phase  = tls_pkg::PH_OCT;
        end else begin
          pre_emit = 1'b1;
        end
      end
      tls_pkg::PH_X: begin
        if (tls_pkg::is_hex(in_byte)) begin
          e_value = {4'd0, hv};
          e_sig   = tls_pkg::HEX_SIG_W'(hv != 4'd0);
          e_ovf   = 1'b0;
          e_phase = tls_pkg::PH_HEX;
        end else begin
          e_phase   = tls_pkg::PH_NONE;
          pre_emit  = 1'b1;
          pre_char  = tls_pkg::CH_X;
          run_plain = 1'b1;
        end
      end
      tls_pkg::PH_HEX: begin
        if (tls_pkg::is_hex(in_byte)) begin
          if (((hex_sig != '0) || (hv != 4'd0)) &&
              (hex_sig <= tls_pkg::HEX_SIG_W'(tls_pkg::HEX_SIG_MAX))) begin
            sig_inc = hex_sig + tls_pkg::HEX_SIG_W'(1);
          end
          e_sig = sig_inc;
          if (sig_inc > tls_pkg::HEX_SIG_W'(tls_pkg::HEX_SIG_MAX)) begin
            e_ovf = 1'b1;
          end
          e_value = {esc_value[3:0], hv};
        end else begin
          e_phase   = tls_pkg::PH_NONE;
          pre_emit  = 1'b1;
          pre_char  = hex_ovf ? tls_pkg::CH_FF : esc_value;
          e_sig     = '0;
          e_ovf     = 1'b0;
          e_value   = 8'h00;
          run_plain = 1'b1;
        end
      end
      tls_pkg::PH_OCT: begin
        if (tls_pkg::is_oct(in_byte)) begin
          e_value  = oct_val;
          e_digits = esc_digits + 2'd1;
          if (esc_digits == 2'd2) begin
            pre_emit = 1'b1;
            pre_char = oct_val;
            e_phase  = tls_pkg::PH_NONE;
            e_value  = 8'h00;
            e_digits = 2'd0;
          end
        end else begin
          pre_emit  = 1'b1;
          pre_char  = esc_value;
          e_phase   = tls_pkg::PH_NONE;
          e_value   = 8'h00;
          e_digits  = 2'd0;
          run_plain = 1'b1;
        end
      end
      tls_pkg::PH_NL: begin
        if ((in_byte != tls_pkg::CH_SPACE) && (in_byte != tls_pkg::CH_TAB)) begin
          e_phase   = tls_pkg::PH_NONE;
          pre_emit  = 1'b1;
          pre_char  = tls_pkg::CH_SPACE;
          run_plain = 1'b1;
        end
      end
      default: begin
        run_plain = 1'b1;
      end
    endcase
  end

  // Next state.
  always_comb begin
    logic clear_all;
    logic fail;
    logic [2:0] fail_code;
    clear_all       = 1'b0;
    fail            = 1'b0;
    fail_code       = tls_pkg::ERR_NONE;
    mode_next       = mode;
    phase_next      = phase;
    depth_next      = depth;
    esc_value_next  = esc_value;
    esc_digits_next = esc_digits;
    hex_sig_next    = hex_sig;
    hex_ovf_next    = hex_ovf;
    held_next       = held;
    if (fire) begin
      unique case (mode)
        tls_pkg::MODE_BETWEEN: begin
          if (c_nul) begin
            clear_all = 1'b1;
          end else if (c_ws) begin
            mode_next = mode;
          end else if (in_byte == tls_pkg::CH_LBRACE) begin
            mode_next  = tls_pkg::MODE_BRACED;
            depth_next = tls_pkg::DEPTH_W'(1);
            phase_next = tls_pkg::PH_NONE;
          end else if (in_byte == tls_pkg::CH_QUOTE) begin
            mode_next  = tls_pkg::MODE_QUOTED;
            phase_next = tls_pkg::PH_NONE;
          end else begin
            mode_next  = tls_pkg::MODE_BARE;
            phase_next = (in_byte == tls_pkg::CH_BSLASH) ? tls_pkg::PH_BS : tls_pkg::PH_NONE;
          end
        end
        tls_pkg::MODE_BARE, tls_pkg::MODE_QUOTED: begin
          phase_next      = e_phase;
          esc_value_next  = e_value;
          esc_digits_next = e_digits;
          hex_sig_next    = e_sig;
          hex_ovf_next    = e_ovf;
          if (run_plain) begin
            if (in_byte == tls_pkg::CH_BSLASH) begin
              phase_next = tls_pkg::PH_BS;
            end else if (c_nul) begin
              clear_all = 1'b1;
            end else if ((mode == tls_pkg::MODE_BARE) && c_ws) begin
              mode_next = tls_pkg::MODE_BETWEEN;
            end else if ((mode == tls_pkg::MODE_QUOTED) && (in_byte == tls_pkg::CH_QUOTE)) begin
              mode_next = tls_pkg::MODE_AFTER_QUOTE;
            end
          end
        end
        tls_pkg::MODE_BRACED: begin
          if (phase != tls_pkg::PH_NONE) begin
            phase_next = tls_pkg::PH_NONE;
            clear_all  = c_nul;
          end else if (c_nul) begin
            clear_all = 1'b1;
          end else if (in_byte == tls_pkg::CH_BSLASH) begin
            phase_next = tls_pkg::PH_BS;
          end else if (in_byte == tls_pkg::CH_LBRACE) begin
            if (depth >= tls_pkg::DEPTH_W'(tls_pkg::MAX_NESTING)) begin
              fail      = 1'b1;
              fail_code = tls_pkg::ERR_NESTING;
            end else begin
              depth_next = depth + tls_pkg::DEPTH_W'(1);
            end
          end else if (in_byte == tls_pkg::CH_RBRACE) begin
            if (depth <= tls_pkg::DEPTH_W'(1)) begin
              depth_next = '0;
              mode_next  = tls_pkg::MODE_AFTER_BRACE;
            end else begin
              depth_next = depth - tls_pkg::DEPTH_W'(1);
            end
          end
        end
        tls_pkg::MODE_AFTER_BRACE, tls_pkg::MODE_AFTER_QUOTE: begin
          if (c_nul) begin
            clear_all = 1'b1;
          end else if (c_ws) begin
            mode_next = tls_pkg::MODE_BETWEEN;
          end else begin
            fail      = 1'b1;
            fail_code = (mode == tls_pkg::MODE_AFTER_BRACE) ? tls_pkg::ERR_JUNK_BRACE
                                                             : tls_pkg::ERR_JUNK_QUOTE;
          end
        end
        default: begin
          clear_all = c_nul;
        end
      endcase
    end
    if (fail) begin
      held_next  = fail_code;
      mode_next  = tls_pkg::MODE_DISCARD;
      phase_next = tls_pkg::PH_NONE;
      depth_next = '0;
    end
    if (clear_all) begin
      mode_next       = tls_pkg::MODE_BETWEEN;
      phase_next      = tls_pkg::PH_NONE;
      depth_next      = '0;
      esc_value_next  = 8'h00;
      esc_digits_next = 2'd0;
      hex_sig_next    = '0;
      hex_ovf_next    = 1'b0;
      held_next       = tls_pkg::ERR_NONE;
    end
  end

  // Results of the current byte.
  always_comb begin
    a_en = 1'b0;
    b_en = 1'b0;
    ra   = tls_pkg::mk_res(pre_char, 1'b1, 1'b0, 1'b0, tls_pkg::ERR_NONE);
    rb   = tls_pkg::mk_res(in_byte, 1'b1, 1'b0, 1'b0, tls_pkg::ERR_NONE);
    unique case (mode)
      tls_pkg::MODE_BETWEEN: begin
        if (c_nul) begin
          b_en = 1'b1;
          rb   = tls_pkg::mk_res(8'h00, 1'b0, 1'b0, 1'b1, tls_pkg::ERR_NONE);
        end else begin
          b_en = !c_ws && (in_byte != tls_pkg::CH_LBRACE) && (in_byte != tls_pkg::CH_QUOTE) &&
                 (in_byte != tls_pkg::CH_BSLASH);
        end
      end
      tls_pkg::MODE_BARE, tls_pkg::MODE_QUOTED: begin
        a_en = pre_emit;
        if (run_plain && (in_byte != tls_pkg::CH_BSLASH)) begin
          if (mode == tls_pkg::MODE_BARE) begin
            b_en = 1'b1;
            if (c_nul) begin
              rb = tls_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b1, tls_pkg::ERR_NONE);
            end else if (c_ws) begin
              rb = tls_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b0, tls_pkg::ERR_NONE);
            end
          end else if (c_nul) begin
            b_en = 1'b1;
            rb   = tls_pkg::mk_res(8'h00, 1'b0, 1'b0, 1'b1, tls_pkg::ERR_UNCLOSED);
          end else begin
            b_en = (in_byte != tls_pkg::CH_QUOTE);
          end
        end
      end
      tls_pkg::MODE_BRACED: begin
        b_en = 1'b1;
        if (c_nul) begin
          rb = tls_pkg::mk_res(8'h00, 1'b0, 1'b0, 1'b1, tls_pkg::ERR_UNCLOSED);
        end else if (phase == tls_pkg::PH_NONE) begin
          if (in_byte == tls_pkg::CH_LBRACE) begin
            b_en = (depth < tls_pkg::DEPTH_W'(tls_pkg::MAX_NESTING));
          end else if (in_byte == tls_pkg::CH_RBRACE) begin
            b_en = (depth > tls_pkg::DEPTH_W'(1));
          end
        end
      end
      tls_pkg::MODE_AFTER_BRACE, tls_pkg::MODE_AFTER_QUOTE: begin
        if (c_nul) begin
          b_en = 1'b1;
          rb   = tls_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b1, tls_pkg::ERR_NONE);
        end else if (c_ws) begin
          b_en = 1'b1;
          rb   = tls_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b0, tls_pkg::ERR_NONE);
        end
      end
      default: begin
        b_en = c_nul;
        rb   = tls_pkg::mk_res(8'h00, 1'b0, 1'b0, 1'b1, held);
      end
    endcase
    push             = fire & (a_en | b_en);
    push_data.two    = a_en & b_en;
    push_data.first  = a_en ? ra : rb;
    push_data.second = rb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= tls_pkg::MODE_BETWEEN;
      phase      <= tls_pkg::PH_NONE;
      depth      <= '0;
      esc_value  <= 8'h00;
      esc_digits <= 2'd0;
      hex_sig    <= '0;
      hex_ovf    <= 1'b0;
      held       <= tls_pkg::ERR_NONE;
    end else begin
      mode       <= mode_next;
      phase      <= phase_next;
      depth      <= depth_next;
      esc_value  <= esc_value_next;
      esc_digits <= esc_digits_next;
      hex_sig    <= hex_sig_next;
      hex_ovf    <= hex_ovf_next;
      held       <= held_next;
    end
  end

endmodule

// ===== sv/tls_queue.sv =====
// Short queue of result bundles between the front end and the back end.
module tls_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tls_pkg::bundle_t  push_data,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output tls_pkg::bundle_t  head
);

  tls_pkg::bundle_t            entries [tls_pkg::QDEPTH];
  logic [tls_pkg::QAW-1:0]     wr_ptr, rd_ptr;
  logic [tls_pkg::QCW-1:0]     count;

  assign not_full  = (count != tls_pkg::QCW'(tls_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tls_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tls_pkg::QAW'(1);
      end
      if (push && !pop) begin
        count <= count + tls_pkg::QCW'(1);
      end else if (pop && !push) begin
        count <= count - tls_pkg::QCW'(1);
      end
    end
  end

endmodule

// ===== sv/tls_back.sv =====
// Back end: hands out the results of each queued bundle one item per cycle while res_ready is high.
module tls_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  tls_pkg::bundle_t  head,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [7:0]        out_byte,
  output logic              out_valid,
  output logic              element_end,
  output logic              list_done,
  output logic [2:0]        error_code,
  output logic              last
);

  logic          idx;
  logic          take;
  tls_pkg::res_t cur;

  assign cur         = idx ? head.second : head.first;
  assign res_valid   = q_valid;
  assign take        = res_valid & res_ready;
  assign last        = idx | ~head.two;
  assign pop         = take & last;
  assign out_byte    = cur.data;
  assign out_valid   = cur.valid;
  assign element_end = cur.eend;
  assign list_done   = cur.done;
  assign error_code  = cur.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 1'b0;
    end else if (take) begin
      idx <= ~last;
    end
  end

endmodule

// ===== sv/tcl_list_splitter.sv =====
// Top level of the streaming Tcl list splitter.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   in_byte
//   result   res_valid / res_ready out_byte, out_valid, element_end, list_done,
//                                  error_code, last
//
// The front end takes one byte per cycle while in_ready is high and turns it into zero, one or two results.
// A four-entry bundle queue sits between the front end and the back end.
// The back end sends one result per cycle while res_ready is high, and a byte that
// yields two results sends them in turn; in_ready falls only while the queue is full.
// Reset is synchronous; there is no clearing pass.
module tcl_list_splitter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       element_end,
  output logic       list_done,
  output logic [2:0] error_code,
  output logic       last
);

  logic             push, pop, not_empty;
  tls_pkg::bundle_t push_data, head;

  tls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .push      (push),
    .push_data (push_data)
  );

  tls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .not_full  (in_ready),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  tls_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (not_empty),
    .head        (head),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .out_byte    (out_byte),
    .out_valid   (out_valid),
    .element_end (element_end),
    .list_done   (list_done),
    .error_code  (error_code),
    .last        (last)
  );

endmodule
